FILE: rtl/mrco_pkg.sv
// Package for the matroid rank and closure oracle.
// Holds field widths, command and register codes, the sequencer state type
// and the control struct for the shared rank unit. No dependencies.
package mrco_pkg;

    // Widths of the item fields.
    localparam int KIND_W      = 1;
    localparam int INDEX_W     = 14;
    localparam int SET_W       = 16;
    localparam int RANK_W      = 6;
    localparam int ELEM_CNT_W  = 5;
    localparam int ENTRY_CNT_W = 15;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

    // Configuration port geometry and register select codes (paddr[2]).
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_ELEMENT_COUNT = 1'b0;
    localparam logic REG_ENTRY_COUNT   = 1'b1;

    // Register reset values.
    localparam logic [ELEM_CNT_W-1:0]  ELEM_CNT_RST  = 5'd16;
    localparam logic [ENTRY_CNT_W-1:0] ENTRY_CNT_RST = 15'd0;

    // Rank value when no basis entry is seen.
    localparam logic signed [RANK_W-1:0] RANK_NONE = -6'sd1;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_PICK,
        S_DONE
    } t_state;

    // Control from the sequencer to the rank unit.
    typedef struct packed {
        logic clear;
        logic vld;
    } t_unit_ctrl;

endpackage

FILE: rtl/mrco_if.sv
// Valid/ready channel interfaces for the oracle's request and result streams.
// Depends on mrco_pkg for the field widths.
interface mrco_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [mrco_pkg::KIND_W-1:0]           kind;
    logic [mrco_pkg::INDEX_W-1:0]          entry_index;
    logic [mrco_pkg::SET_W-1:0]            entry_set;
    logic                                  entry_is_basis;
    logic [mrco_pkg::SET_W-1:0]            query_set;

    modport source (
        output valid, kind, entry_index, entry_set, entry_is_basis, query_set,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_index, entry_set, entry_is_basis, query_set,
        output ready
    );
endinterface

interface mrco_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mrco_pkg::RANK_W-1:0]    rank_value;
    logic [mrco_pkg::SET_W-1:0]            closure_set;

    modport source (
        output valid, rank_value, closure_set,
        input  ready
    );
    modport sink (
        input  valid, rank_value, closure_set,
        output ready
    );
endinterface

FILE: rtl/mrco_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mrco_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16384,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic [WIDTH-1:0]        i_wdata,
    input  logic [AW-1:0]           i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/mrco_cfg_regs.sv
// APB-style configuration registers: element count and entry count.
// Depends on mrco_pkg for widths, reset values and register codes.
module mrco_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mrco_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mrco_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mrco_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [mrco_pkg::ELEM_CNT_W-1:0]    o_element_count,
    output logic [mrco_pkg::ENTRY_CNT_W-1:0]   o_entry_count
);
    logic [mrco_pkg::ELEM_CNT_W-1:0]  r_element_count;
    logic [mrco_pkg::ENTRY_CNT_W-1:0] r_entry_count;
    logic                             wr_en;
    logic                             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[mrco_pkg::REG_SEL_BIT];

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_count <= mrco_pkg::ELEM_CNT_RST;
            r_entry_count   <= mrco_pkg::ENTRY_CNT_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                mrco_pkg::REG_ELEMENT_COUNT: begin
                    r_element_count <= pwdata[mrco_pkg::ELEM_CNT_W-1:0];
                end
                mrco_pkg::REG_ENTRY_COUNT: begin
                    r_entry_count <= pwdata[mrco_pkg::ENTRY_CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read mux.
    always_comb begin
        unique case (reg_sel)
            mrco_pkg::REG_ELEMENT_COUNT: prdata = mrco_pkg::APB_DATA_W'(r_element_count);
            mrco_pkg::REG_ENTRY_COUNT:   prdata = mrco_pkg::APB_DATA_W'(r_entry_count);
            default:                     prdata = '0;
        endcase
    end

    assign o_element_count = r_element_count;
    assign o_entry_count   = r_entry_count;
endmodule

FILE: rtl/mrco_rank_unit.sv
// Shared rank unit: popcount of the test set ANDed with one table entry,
// kept as a running maximum over flagged entries. Depends on mrco_pkg.
module mrco_rank_unit #(
    parameter int SW = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mrco_pkg::t_unit_ctrl                i_ctrl,
    input  logic [SW-1:0]                       i_test_set,
    input  logic [SW-1:0]                       i_entry_set,
    input  logic                                i_entry_flag,
    output logic signed [mrco_pkg::RANK_W-1:0]  o_best
);
    logic signed [mrco_pkg::RANK_W-1:0] r_best;
    logic signed [mrco_pkg::RANK_W-1:0] n_best;
    logic [SW-1:0]                      masked;
    logic [mrco_pkg::RANK_W-1:0]        cnt;

    // Population count of the intersection.
    always_comb begin
        masked = i_test_set & i_entry_set;
        cnt    = '0;
        for (int k = 0; k < SW; k++) begin
            cnt = cnt + mrco_pkg::RANK_W'(masked[k]);
        end
    end

    // Running maximum over flagged entries.
    always_comb begin
        n_best = r_best;
        if (i_ctrl.clear) begin
            n_best = mrco_pkg::RANK_NONE;
        end else if (i_ctrl.vld && i_entry_flag && ($signed(cnt) > r_best)) begin
            n_best = $signed(cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= mrco_pkg::RANK_NONE;
        end else begin
            r_best <= n_best;
        end
    end

    assign o_best = r_best;
endmodule

FILE: rtl/matroid_rank_closure_oracle_unit.sv
// Top level of the matroid rank and closure oracle: query sequencer, table
// RAM, rank unit and configuration port. Depends on mrco_pkg, mrco_if,
// mrco_ram, mrco_rank_unit and mrco_cfg_regs.
//
// Requests arrive on i_req (valid/ready). A load transfer writes one table
// entry (subset and basis flag) in the cycle it is accepted, if its index is
// below MAX_ENTRIES, and gives no result. A query transfer gives one result
// on o_rsp: the rank of the query set and its closure. Set bits above
// min(SET_WIDTH, 16) are ignored. A query runs as a series of passes over
// the table, all through one shared popcount-and-maximum unit fed by the RAM
// read port, one entry per cycle. With L = min(entry_count, MAX_ENTRIES),
// each pass reads entries 0 to L - 1; there is one rank pass plus one trial
// pass per element below min(element_count, SET_WIDTH) that is not yet in
// the set, and elements already in the set are skipped. i_req.ready is low
// until the query is finished. The result sits in an output register; while
// o_rsp is stalled the block still accepts and works on the next request,
// and only a second finished query waits for the register to drain. Reset
// clears the control state and sets the configuration registers to their
// reset values; table contents are undefined until loaded.
module matroid_rank_closure_oracle_unit #(
    parameter int SET_WIDTH   = 16,
    parameter int MAX_ENTRIES = 16384
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    mrco_req_if.sink                           i_req,
    mrco_rsp_if.source                         o_rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mrco_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mrco_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mrco_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    localparam int SW = (SET_WIDTH < mrco_pkg::SET_W) ? SET_WIDTH : mrco_pkg::SET_W;
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = $clog2(SW + 1);
    localparam int IW = $clog2(SW);

    // Configuration.
    logic [mrco_pkg::ELEM_CNT_W-1:0]  element_count;
    logic [mrco_pkg::ENTRY_CNT_W-1:0] entry_count;

    mrco_cfg_regs u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_element_count (element_count),
        .o_entry_count   (entry_count)
    );

    // Sequencer and datapath registers.
    mrco_pkg::t_state                    r_state,     n_state;
    logic [CW-1:0]                       r_addr,      n_addr;
    logic [CW-1:0]                       r_limit,     n_limit;
    logic [EW-1:0]                       r_lim_el,    n_lim_el;
    logic [EW-1:0]                       r_elem,      n_elem;
    logic                                r_phase,     n_phase;
    logic [SW-1:0]                       r_cl,        n_cl;
    logic [SW-1:0]                       r_test,      n_test;
    logic signed [mrco_pkg::RANK_W-1:0]  r_rq,        n_rq;
    logic                                r_out_valid, n_out_valid;
    logic signed [mrco_pkg::RANK_W-1:0]  r_out_rank,  n_out_rank;
    logic [SW-1:0]                       r_out_cl,    n_out_cl;
    logic                                r_rd_vld,    n_rd_vld;

    logic                                ram_we;
    logic [AW-1:0]                       ram_waddr;
    logic [SW:0]                         ram_wdata;
    logic [SW:0]                         ram_rdata;
    mrco_pkg::t_unit_ctrl                unit_ctrl;
    logic signed [mrco_pkg::RANK_W-1:0]  best;
    logic [SW-1:0]                       query_in;
    logic [SW-1:0]                       elem_bit;
    logic                                idx_ok;
    logic [CW-1:0]                       lim_calc;
    logic [EW-1:0]                       el_calc;

    // Table of subsets with the basis flag in the top bit.
    mrco_ram #(
        .WIDTH (SW + 1),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Shared popcount and maximum unit.
    mrco_rank_unit #(
        .SW (SW)
    ) u_rank (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (unit_ctrl),
        .i_test_set   (r_test),
        .i_entry_set  (ram_rdata[SW-1:0]),
        .i_entry_flag (ram_rdata[SW]),
        .o_best       (best)
    );

    // Request decode and clamped limits.
    assign query_in  = i_req.query_set[SW-1:0];
    assign ram_waddr = AW'(i_req.entry_index);
    assign ram_wdata = {i_req.entry_is_basis, i_req.entry_set[SW-1:0]};
    assign idx_ok    = 32'(i_req.entry_index) < 32'(MAX_ENTRIES);
    assign lim_calc  = (32'(entry_count) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                             : CW'(entry_count);
    assign el_calc   = (32'(element_count) > 32'(SW)) ? EW'(SW) : EW'(element_count);
    assign elem_bit  = SW'(1) << r_elem[IW-1:0];

    assign i_req.ready = (r_state == mrco_pkg::S_IDLE);

    // Next state and datapath control.
    always_comb begin
        n_state         = r_state;
        n_addr          = r_addr;
        n_limit         = r_limit;
        n_lim_el        = r_lim_el;
        n_elem          = r_elem;
        n_phase         = r_phase;
        n_cl            = r_cl;
        n_test          = r_test;
        n_rq            = r_rq;
        n_out_valid     = r_out_valid && !o_rsp.ready;
        n_out_rank      = r_out_rank;
        n_out_cl        = r_out_cl;
        n_rd_vld        = (r_state == mrco_pkg::S_SCAN);
        ram_we          = 1'b0;
        unit_ctrl.clear = 1'b0;
        unit_ctrl.vld   = r_rd_vld;

        unique case (r_state)
            mrco_pkg::S_IDLE: begin
                unit_ctrl.clear = 1'b1;
                if (i_req.valid) begin
                    if (i_req.kind == mrco_pkg::KIND_QUERY) begin
                        n_cl     = query_in;
                        n_test   = query_in;
                        n_phase  = 1'b0;
                        n_elem   = '0;
                        n_limit  = lim_calc;
                        n_lim_el = el_calc;
                        n_state  = mrco_pkg::S_START;
                    end else begin
                        ram_we = idx_ok;
                    end
                end
            end
            mrco_pkg::S_START: begin
                // Begin one pass over the table.
                unit_ctrl.clear = 1'b1;
                n_addr          = '0;
                n_state         = (r_limit == '0) ? mrco_pkg::S_DECIDE : mrco_pkg::S_SCAN;
            end
            mrco_pkg::S_SCAN: begin
                n_addr = r_addr + CW'(1);
                if (r_addr == r_limit - CW'(1)) begin
                    n_state = mrco_pkg::S_DRAIN;
                end
            end
            mrco_pkg::S_DRAIN: begin
                // Last read data enters the rank unit.
                n_state = mrco_pkg::S_DECIDE;
            end
            mrco_pkg::S_DECIDE: begin
                // Rank pass stores the query rank; a trial keeps its element
                // only if the rank did not rise.
                unit_ctrl.clear = 1'b1;
                if (!r_phase) begin
                    n_rq = best;
                end else begin
                    if (best <= r_rq) begin
                        n_cl = r_cl | elem_bit;
                    end
                    n_elem = r_elem + EW'(1);
                end
                n_state = mrco_pkg::S_PICK;
            end
            mrco_pkg::S_PICK: begin
                // Find the next element not yet in the closure.
                if (r_elem >= r_lim_el) begin
                    n_state = mrco_pkg::S_DONE;
                end else if (r_cl[r_elem[IW-1:0]]) begin
                    n_elem = r_elem + EW'(1);
                end else begin
                    n_test  = r_cl | elem_bit;
                    n_phase = 1'b1;
                    n_state = mrco_pkg::S_START;
                end
            end
            mrco_pkg::S_DONE: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_rank  = r_rq;
                    n_out_cl    = r_cl;
                    n_state     = mrco_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mrco_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mrco_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rd_vld    <= n_rd_vld;
            r_phase     <= n_phase;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_limit    <= n_limit;
        r_lim_el   <= n_lim_el;
        r_elem     <= n_elem;
        r_cl       <= n_cl;
        r_test     <= n_test;
        r_rq       <= n_rq;
        r_out_rank <= n_out_rank;
        r_out_cl   <= n_out_cl;
    end

    // Result channel.
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.rank_value  = r_out_rank;
    assign o_rsp.closure_set = mrco_pkg::SET_W'(r_out_cl);
endmodule

FILE: tb/tb.sv
// Testbench for matroid_rank_closure_oracle_unit: loads subset tables and asks
// rank and closure queries, checking every result against a predictor kept here.
// Depends on mrco_pkg and the mrco_req_if and mrco_rsp_if interfaces.
module tb;

    localparam int TABLE_DEPTH   = 16384;
    localparam int LIVE_ENTRIES  = 32;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 2_000_000;

    typedef struct {
        logic [mrco_pkg::KIND_W-1:0]  kind;
        logic [mrco_pkg::INDEX_W-1:0] entry_index;
        logic [mrco_pkg::SET_W-1:0]   entry_set;
        logic                         entry_is_basis;
        logic [mrco_pkg::SET_W-1:0]   query_set;
    } t_oracle_req;

    typedef struct {
        logic signed [mrco_pkg::RANK_W-1:0] rank_value;
        logic [mrco_pkg::SET_W-1:0]         closure_set;
    } t_oracle_answer;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [mrco_pkg::APB_ADDR_W-1:0] paddr;
    logic [mrco_pkg::APB_DATA_W-1:0] pwdata;
    logic [mrco_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    mrco_req_if req_ch ();
    mrco_rsp_if rsp_ch ();

    matroid_rank_closure_oracle_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Requests waiting to be driven and answers waiting to come back.
    t_oracle_req    pending_q[$];
    t_oracle_answer answer_q[$];

    // Shadow of the subset table and of the configuration registers.
    logic [mrco_pkg::SET_W-1:0] tbl_set   [TABLE_DEPTH];
    bit                         tbl_basis [TABLE_DEPTH];
    int unsigned                cfg_elem_count;
    int unsigned                cfg_entry_count;

    int send_idle_pct;
    int stall_pct;
    int fail_count;
    int cycle_count;

    // Free-running clock.
    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("cycle %0d: %s", cycle_count, msg);
    endtask

    // Append one request to the tail of the pending queue.
    task automatic enqueue_req(input t_oracle_req it);
        pending_q.insert(pending_q.size(), it);
    endtask

    // Rank of a set: largest overlap with any flagged entry in the scanned range.
    function automatic int rank_of(input logic [mrco_pkg::SET_W-1:0] s);
        int best;
        int ones;
        int unsigned lim;
        int unsigned i;
        best = -1;
        lim = (cfg_entry_count > TABLE_DEPTH) ? TABLE_DEPTH : cfg_entry_count;
        for (i = 0; i < lim; i++) begin
            if (tbl_basis[i]) begin
                ones = $countones(s & tbl_set[i]);
                if (ones > best) best = ones;
            end
        end
        return best;
    endfunction

    // Rank of the query, then grow the closure one element at a time.
    function automatic t_oracle_answer predict_answer(input logic [mrco_pkg::SET_W-1:0] q);
        t_oracle_answer ans;
        int base_rank;
        int unsigned lim;
        int unsigned i;
        logic [mrco_pkg::SET_W-1:0] grown;
        base_rank = rank_of(q);
        grown = q;
        lim = (cfg_elem_count > mrco_pkg::SET_W) ? mrco_pkg::SET_W : cfg_elem_count;
        for (i = 0; i < lim; i++) begin
            if (!grown[i] && rank_of(grown | (mrco_pkg::SET_W'(1) << i)) <= base_rank)
                grown[i] = 1'b1;
        end
        ans.rank_value  = base_rank[mrco_pkg::RANK_W-1:0];
        ans.closure_set = grown;
        return ans;
    endfunction

    // A load updates the shadow table; a query queues its expected answer.
    task automatic apply_transfer(input t_oracle_req it);
        if (it.kind == mrco_pkg::KIND_LOAD) begin
            tbl_set[it.entry_index]   = it.entry_set;
            tbl_basis[it.entry_index] = it.entry_is_basis;
        end else begin
            answer_q.insert(answer_q.size(), predict_answer(it.query_set));
        end
    endtask

    function automatic t_oracle_req load_item(input int idx,
                                              input logic [mrco_pkg::SET_W-1:0] s,
                                              input bit flag);
        t_oracle_req it;
        it.kind           = mrco_pkg::KIND_LOAD;
        it.entry_index    = mrco_pkg::INDEX_W'(idx);
        it.entry_set      = s;
        it.entry_is_basis = flag;
        it.query_set      = mrco_pkg::SET_W'($urandom);
        return it;
    endfunction

    function automatic t_oracle_req query_item(input logic [mrco_pkg::SET_W-1:0] q);
        t_oracle_req it;
        it.kind           = mrco_pkg::KIND_QUERY;
        it.entry_index    = mrco_pkg::INDEX_W'($urandom);
        it.entry_set      = mrco_pkg::SET_W'($urandom);
        it.entry_is_basis = 1'($urandom);
        it.query_set      = q;
        return it;
    endfunction

    // Mix of queries (often sparse) and loads, mostly into the scanned range.
    function automatic t_oracle_req random_item();
        int sel;
        int idx;
        logic [mrco_pkg::SET_W-1:0] s;
        if ($urandom_range(99) < 50) begin
            sel = $urandom_range(9);
            if (sel == 0) s = '0;
            else if (sel == 1) s = '1;
            else if (sel < 6) s = mrco_pkg::SET_W'($urandom & $urandom & $urandom);
            else s = mrco_pkg::SET_W'($urandom);
            return query_item(s);
        end
        idx = ($urandom_range(9) == 0) ? $urandom_range(TABLE_DEPTH - 1)
                                       : $urandom_range(LIVE_ENTRIES - 1);
        s = $urandom_range(1) ? mrco_pkg::SET_W'($urandom)
                              : mrco_pkg::SET_W'($urandom | $urandom);
        return load_item(idx, s, $urandom_range(99) < 60);
    endfunction

    // Request driver: holds an item until its transfer, then maybe idles.
    always @(posedge i_clk) begin : drive_requests
        t_oracle_req taken;
        t_oracle_req nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                taken.kind           = req_ch.kind;
                taken.entry_index    = req_ch.entry_index;
                taken.entry_set      = req_ch.entry_set;
                taken.entry_is_basis = req_ch.entry_is_basis;
                taken.query_set      = req_ch.query_set;
                apply_transfer(taken);
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_q.pop_front();
                    req_ch.valid          <= 1'b1;
                    req_ch.kind           <= nxt.kind;
                    req_ch.entry_index    <= nxt.entry_index;
                    req_ch.entry_set      <= nxt.entry_set;
                    req_ch.entry_is_basis <= nxt.entry_is_basis;
                    req_ch.query_set      <= nxt.query_set;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each result transfer with the oldest answer.
    always @(posedge i_clk) begin : check_results
        t_oracle_answer want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch($sformatf("result with no query waiting: rank %0d closure %h",
                                              rsp_ch.rank_value, rsp_ch.closure_set));
                end else begin
                    want = answer_q.pop_front();
                    if (rsp_ch.rank_value !== want.rank_value)
                        report_mismatch($sformatf("rank_value %0d, expected %0d",
                                                  rsp_ch.rank_value, want.rank_value));
                    if (rsp_ch.closure_set !== want.closure_set)
                        report_mismatch($sformatf("closure_set %h, expected %h",
                                                  rsp_ch.closure_set, want.closure_set));
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Cycle count and timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_register(input logic code, input int unsigned value);
        logic [mrco_pkg::APB_ADDR_W-1:0] addr;
        addr = '0;
        addr[mrco_pkg::REG_SEL_BIT] = code;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (code == mrco_pkg::REG_ELEMENT_COUNT) cfg_elem_count = value & 32'h1f;
        else cfg_entry_count = value & 32'h7fff;
    endtask

    task automatic set_counts(input int unsigned elems, input int unsigned entries);
        write_register(mrco_pkg::REG_ELEMENT_COUNT, elems);
        write_register(mrco_pkg::REG_ENTRY_COUNT, entries);
    endtask

    // Wait until every item went out and every answer came back, then settle.
    task automatic wait_for_drain();
        @(negedge i_clk);
        while (pending_q.size() != 0 || req_ch.valid || answer_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Stimulus sequence.
    initial begin
        t_oracle_req it;
        int p;
        int k;
        int unsigned elems;
        int unsigned entries;

        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        req_ch.valid          = 1'b0;
        req_ch.kind           = mrco_pkg::KIND_LOAD;
        req_ch.entry_index    = '0;
        req_ch.entry_set      = '0;
        req_ch.entry_is_basis = 1'b0;
        req_ch.query_set      = '0;
        rsp_ch.ready          = 1'b0;
        cfg_elem_count        = 32'(mrco_pkg::ELEM_CNT_RST);
        cfg_entry_count       = 32'(mrco_pkg::ENTRY_CNT_RST);
        send_idle_pct         = 0;
        stall_pct             = 0;
        fail_count            = 0;
        cycle_count           = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty scan range: no basis, so every element joins the closure.
        enqueue_req(query_item(16'h0000));
        enqueue_req(query_item(16'hffff));
        enqueue_req(load_item(0, 16'h0f0f, 1'b1));
        enqueue_req(load_item(1, 16'h00f0, 1'b0));
        enqueue_req(load_item(2, 16'h8001, 1'b1));
        enqueue_req(load_item(3, 16'hf000, 1'b1));
        enqueue_req(load_item(TABLE_DEPTH - 1, 16'h5a5a, 1'b1));
        it.kind           = mrco_pkg::KIND_QUERY;
        it.entry_index    = '1;
        it.entry_set      = '1;
        it.entry_is_basis = 1'b1;
        it.query_set      = 16'h0003;
        enqueue_req(it);
        wait_for_drain();

        // No elements tried: the closure is the query itself.
        set_counts(0, 4);
        enqueue_req(query_item(16'h1234));
        enqueue_req(query_item(16'hffff));
        wait_for_drain();

        // Element count above the set width.
        set_counts(31, 4);
        enqueue_req(query_item(16'h0001));
        enqueue_req(query_item(16'h8000));
        enqueue_req(query_item(16'h0000));
        enqueue_req(query_item(16'h00f0));
        enqueue_req(load_item(4, 16'hffff, 1'b1));
        wait_for_drain();

        // Full-width basis gives the top rank.
        set_counts(16, 5);
        enqueue_req(query_item(16'hffff));
        enqueue_req(query_item(16'h0101));
        enqueue_req(load_item(0, 16'hffff, 1'b0));
        enqueue_req(load_item(1, 16'h0000, 1'b0));
        wait_for_drain();

        // Entries present but none flagged.
        set_counts(1, 2);
        enqueue_req(query_item(16'h0000));
        wait_for_drain();

        // Fill the live range so every scanned entry has been written.
        for (k = 0; k < LIVE_ENTRIES; k++)
            enqueue_req(load_item(k, mrco_pkg::SET_W'($urandom | $urandom),
                                  $urandom_range(99) < 60));
        wait_for_drain();

        // Random traffic under each idling profile, two settings per profile.
        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 65; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 65; end
                default: begin send_idle_pct = 16; stall_pct = 16; end
            endcase
            repeat (2) begin
                case ($urandom_range(4))
                    0: elems = 0;
                    1: elems = 1;
                    2: elems = 16;
                    3: elems = 31;
                    default: elems = $urandom_range(31);
                endcase
                case ($urandom_range(3))
                    0: entries = 0;
                    1: entries = LIVE_ENTRIES;
                    default: entries = $urandom_range(LIVE_ENTRIES, 1);
                endcase
                set_counts(elems, entries);
                repeat (6) enqueue_req(random_item());
                wait_for_drain();
            end
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: matroid_rank_closure_oracle_unit.f
rtl/mrco_pkg.sv
rtl/mrco_if.sv
rtl/mrco_ram.sv
rtl/mrco_cfg_regs.sv
rtl/mrco_rank_unit.sv
rtl/matroid_rank_closure_oracle_unit.sv
tb/tb.sv
